// File: rtl/core/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// Holds status and opcode codes, the block table entry layout and the
// command and status structs between the controller and the datapath.
package ffba_pkg;

    localparam int unsigned HEADER_BYTES = 16;
    localparam logic [31:0] HEADER_32    = 32'(HEADER_BYTES);
    localparam logic [33:0] HEADER_34    = 34'(HEADER_BYTES);

    localparam logic [31:0] HEAP_BASE_RST  = 32'd0;
    localparam logic [31:0] HEAP_LIMIT_RST = 32'd65536;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NULL    = 2'd1,
        ST_NOMEM   = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_opcode;

    typedef enum logic {
        CFG_HEAP_BASE  = 1'b0,
        CFG_HEAP_LIMIT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
        logic        is_free;
    } t_entry;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit_hit;
        logic commit_miss;
        logic finish_null;
    } t_dp_cmd;

    typedef struct packed {
        logic is_null;
        logic hit;
        logic exhausted;
    } t_dp_stat;

endpackage

// File: rtl/core/ffba_ctrl.sv
// Controller state machine of the first-fit block allocator.
// Depends on ffba_pkg for the command and status structs.
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_HIT,
        S_MISS
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_CHECK;
                        r_busy  <= 1'b1;
                    end
                end
                S_CHECK: begin
                    if (i_stat.is_null) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    priority if (i_stat.hit) begin
                        r_state <= S_HIT;
                    end else if (i_stat.exhausted) begin
                        r_state <= S_MISS;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_HIT, S_MISS: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.load        = (r_state == S_IDLE) && i_start;
        o_cmd.finish_null = (r_state == S_CHECK) && i_stat.is_null;
        o_cmd.scan        = (r_state == S_SCAN);
        o_cmd.commit_hit  = (r_state == S_HIT);
        o_cmd.commit_miss = (r_state == S_MISS);
    end

    assign o_busy = r_busy;

endmodule

// File: rtl/core/ffba_dp.sv
// Datapath of the first-fit block allocator: block table memory, scan
// pipeline, heap bookkeeping, configuration and result registers.
// Depends on ffba_pkg; driven by ffba_ctrl through t_dp_cmd.
module ffba_dp
    import ffba_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_opcode,
    input  logic [31:0] i_request_size,
    input  logic [31:0] i_release_address,
    output logic        o_valid,
    output logic [31:0] o_payload_address,
    output t_status     o_status
);

    localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

    t_entry r_mem [MAX_BLOCKS];

    logic [31:0]      r_base;
    logic [31:0]      r_limit;
    logic [CNT_W-1:0] r_count;
    logic [31:0]      r_top;
    logic             r_op;
    logic [31:0]      r_arg;
    logic [31:0]      r_key;
    logic [CNT_W-1:0] r_scan_addr;
    logic             r_pend;
    logic [IDX_W-1:0] r_pend_idx;
    t_entry           r_rd_data;
    logic [IDX_W-1:0] r_sel_idx;
    t_entry           r_sel;
    logic             r_valid;
    logic [31:0]      r_addr_out;
    t_status          r_status;

    logic             match;
    logic             hit;
    logic             issue;
    logic [33:0]      sel_end;
    logic [33:0]      app_end;
    logic             remove;
    logic             nomem;
    logic [31:0]      sel_payload;
    logic [31:0]      top_payload;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    t_entry           wr_data;

    // An allocate looks for a free block that is large enough; a release
    // compares header offsets against the offset derived from its address.
    assign match = (r_op == OP_ALLOC)
                 ? (r_rd_data.is_free && (r_rd_data.length >= r_arg))
                 : (r_rd_data.start == r_key);
    assign hit   = r_pend && match;
    assign issue = i_cmd.scan && !hit && (r_scan_addr < r_count);

    assign o_stat.is_null   = (r_arg == 32'd0);
    assign o_stat.hit       = hit;
    assign o_stat.exhausted = !r_pend && (r_scan_addr >= r_count);

    assign sel_end = {2'b00, r_sel.start} + HEADER_34 + {2'b00, r_sel.length};
    assign remove  = (sel_end == {2'b00, r_top})
                  && ((CNT_W'(r_sel_idx) + CNT_W'(1)) == r_count);
    assign app_end = {2'b00, r_top} + HEADER_34 + {2'b00, r_arg};
    assign nomem   = (app_end > {2'b00, r_limit}) || (r_count == CNT_W'(MAX_BLOCKS));

    assign sel_payload = r_base + r_sel.start + HEADER_32;
    assign top_payload = r_base + r_top + HEADER_32;

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = r_sel_idx;
        wr_data = r_sel;
        if (i_cmd.commit_hit) begin
            if (r_op == OP_ALLOC) begin
                wr_en           = 1'b1;
                wr_data.is_free = 1'b0;
            end else if (!remove) begin
                wr_en           = 1'b1;
                wr_data.is_free = 1'b1;
            end
        end else if (i_cmd.commit_miss && (r_op == OP_ALLOC) && !nomem) begin
            wr_en           = 1'b1;
            wr_idx          = r_count[IDX_W-1:0];
            wr_data.start   = r_top;
            wr_data.length  = r_arg;
            wr_data.is_free = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (issue) begin
            r_rd_data  <= r_mem[r_scan_addr[IDX_W-1:0]];
            r_pend_idx <= r_scan_addr[IDX_W-1:0];
        end
        if (hit) begin
            r_sel     <= r_rd_data;
            r_sel_idx <= r_pend_idx;
        end
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_arg <= (i_opcode == OP_ALLOC) ? i_request_size : i_release_address;
            r_key <= i_release_address - r_base - HEADER_32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= HEAP_BASE_RST;
            r_limit     <= HEAP_LIMIT_RST;
            r_count     <= '0;
            r_top       <= '0;
            r_scan_addr <= '0;
            r_pend      <= 1'b0;
            r_valid     <= 1'b0;
            r_addr_out  <= '0;
            r_status    <= ST_OK;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HEAP_BASE:  r_base  <= i_cfg_data;
                    CFG_HEAP_LIMIT: r_limit <= i_cfg_data;
                    default:        r_base  <= r_base;
                endcase
            end

            if (i_cmd.load) begin
                r_scan_addr <= '0;
            end else if (issue) begin
                r_scan_addr <= r_scan_addr + CNT_W'(1);
            end
            r_pend <= issue;

            r_valid <= i_cmd.finish_null || i_cmd.commit_hit || i_cmd.commit_miss;

            priority if (i_cmd.finish_null) begin
                r_addr_out <= '0;
                r_status   <= ST_NULL;
            end else if (i_cmd.commit_hit) begin
                r_status   <= ST_OK;
                if (r_op == OP_ALLOC) begin
                    r_addr_out <= sel_payload;
                end else begin
                    r_addr_out <= '0;
                    if (remove) begin
                        r_top   <= r_sel.start;
                        r_count <= CNT_W'(r_sel_idx);
                    end
                end
            end else if (i_cmd.commit_miss) begin
                if (r_op == OP_RELEASE) begin
                    r_addr_out <= '0;
                    r_status   <= ST_UNKNOWN;
                end else if (nomem) begin
                    r_addr_out <= '0;
                    r_status   <= ST_NOMEM;
                end else begin
                    r_addr_out <= top_payload;
                    r_status   <= ST_OK;
                    r_top      <= app_end[31:0];
                    r_count    <= r_count + CNT_W'(1);
                end
            end else begin
                // Between results the result registers hold their value.
                r_addr_out <= r_addr_out;
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_payload_address = r_addr_out;
    assign o_status          = r_status;

endmodule

// File: rtl/core/first_fit_block_allocator.sv
// Top level of the first-fit block allocator.
// Instantiates ffba_ctrl and ffba_dp; depends on ffba_pkg.
//
// Usage: a command transaction is taken at a rising edge where start is
// high and busy is low. i_opcode selects allocate or release; allocate
// uses i_request_size, release uses i_release_address. Every command
// produces exactly one result transaction: o_valid is high for one cycle
// with o_payload_address and o_status. The receiver cannot stall, so the
// result is simply presented for that single cycle.
// A null request (zero size or zero address) is answered after the null
// check. Otherwise the block table is walked one entry per cycle through
// the registered read port of the table memory until an entry matches or
// the live blocks run out; a commit state then updates the table.
// A new command may be started in the cycle in which the result is shown.
// Configuration writes (heap base, heap limit) take effect at once; the
// user must make them only while the block is idle, which the block itself
// does not enforce. Reset empties the table, puts the heap top at the heap
// base and restores base 0 and limit 65536; no clearing pass is needed
// because only entries below the block count are read.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [31:0] i_request_size,
    input  logic [31:0] i_release_address,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [31:0] o_payload_address,
    output logic [1:0]  o_status
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_status  status;

    // The controller sequences each transaction: null check, table walk,
    // then a commit state that updates the table and loads the result.
    ffba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // The datapath owns the block table memory, heap top, block count,
    // configuration registers and the result registers.
    ffba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_opcode          (i_opcode),
        .i_request_size    (i_request_size),
        .i_release_address (i_release_address),
        .o_valid           (o_valid),
        .o_payload_address (o_payload_address),
        .o_status          (status)
    );

    assign o_status = status;

endmodule

// File: rtl/core/ffba_checker.sv
// Port-level checks for the first-fit block allocator, bound to the top.
// Depends on ffba_pkg for the status codes.
module ffba_checker
    import ffba_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_opcode,
    input logic [31:0] i_request_size,
    input logic [31:0] i_release_address,
    input logic        o_valid,
    input logic [31:0] o_payload_address,
    input logic [1:0]  o_status
);

    // An accepted transaction makes the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted command");

    // A result is only shown once the block has finished its work.
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // Every end of work comes with exactly its result.
    a_done_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy fell without a result");

    // Failures never carry an address (releases are not checked here).
    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_payload_address == 32'd0))
        else $error("nonzero address on a failed transaction");

    // A zero-size allocate or a zero-address release is answered as a null
    // request from the null check state, through the result registers.
    a_null_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy
         && (((i_opcode == OP_ALLOC) && (i_request_size == 32'd0))
          || ((i_opcode == OP_RELEASE) && (i_release_address == 32'd0))))
        |=> ##1 (o_valid && (o_status == ST_NULL)))
        else $error("null request not answered as such");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .i_opcode          (i_opcode),
    .i_request_size    (i_request_size),
    .i_release_address (i_release_address),
    .o_valid           (o_valid),
    .o_payload_address (o_payload_address),
    .o_status          (o_status)
);

// File: bench/tb.sv
// Self-checking testbench for first_fit_block_allocator: directed table, then random phases.
// A behavioral heap model predicts every result; depends on ffba_pkg and the allocator RTL.
module tb;
    import ffba_pkg::*;

    localparam int unsigned TBL_DEPTH  = 64;
    // Extra wait after the final drain, scaled with the table depth.
    localparam int unsigned DRAIN_CYCLES = TBL_DEPTH + 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_opcode;
    logic [31:0] i_request_size;
    logic [31:0] i_release_address;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_valid;
    logic [31:0] o_payload_address;
    logic [1:0]  o_status;

    first_fit_block_allocator #(
        .MAX_BLOCKS(TBL_DEPTH)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_request_size    (i_request_size),
        .i_release_address (i_release_address),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_payload_address (o_payload_address),
        .o_status          (o_status)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // One expected result transaction.
    typedef struct {
        logic [31:0] addr;
        t_status     st;
    } t_heap_result;

    // One row of the directed table. When has_exp is set the typed result is
    // the expectation; otherwise the heap model supplies it.
    typedef struct {
        t_opcode     op;
        logic [31:0] size;
        logic [31:0] addr;
        bit          has_exp;
        logic [31:0] exp_addr;
        t_status     exp_st;
    } t_heap_row;

    // Settings for one random phase; alloc_pct biases allocate against release.
    typedef struct {
        logic [31:0] base;
        logic [31:0] limit;
        int unsigned alloc_pct;
    } t_heap_phase;

    // Directed sequence, starting from the reset state (base 0, limit 65536).
    // The comments track the heap top so the typed values can be checked by eye.
    localparam int unsigned N_ROWS = 24;
    t_heap_row directed_rows [N_ROWS] = '{
        '{OP_ALLOC,   32'd0,          32'd0,          1'b1, 32'd0,  ST_NULL},
        '{OP_RELEASE, 32'd0,          32'd0,          1'b1, 32'd0,  ST_NULL},
        '{OP_RELEASE, 32'd0,          32'hFFFF_FFFF,  1'b1, 32'd0,  ST_UNKNOWN},
        '{OP_ALLOC,   32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd0,  ST_NOMEM},
        '{OP_ALLOC,   32'd100,        32'd0,          1'b1, 32'd16, ST_OK},      // top 116
        '{OP_ALLOC,   32'd200,        32'd0,          1'b0, 32'd0,  ST_OK},      // top 332
        '{OP_ALLOC,   32'd65536,      32'd0,          1'b1, 32'd0,  ST_NOMEM},
        '{OP_RELEASE, 32'd0,          32'd16,         1'b0, 32'd0,  ST_OK},      // first freed
        '{OP_ALLOC,   32'd50,         32'd0,          1'b0, 32'd0,  ST_OK},      // reuses it
        '{OP_ALLOC,   32'd101,        32'd0,          1'b0, 32'd0,  ST_OK},      // appended
        '{OP_RELEASE, 32'd0,          32'd348,        1'b0, 32'd0,  ST_OK},      // top shrinks
        '{OP_RELEASE, 32'd0,          32'd348,        1'b1, 32'd0,  ST_UNKNOWN},
        '{OP_RELEASE, 32'd0,          32'd17,         1'b1, 32'd0,  ST_UNKNOWN},
        '{OP_ALLOC,   32'd65188,      32'd0,          1'b0, 32'd0,  ST_OK},      // fills limit
        '{OP_ALLOC,   32'd1,          32'd0,          1'b1, 32'd0,  ST_NOMEM},
        '{OP_RELEASE, 32'd0,          32'd348,        1'b0, 32'd0,  ST_OK},
        '{OP_RELEASE, 32'd0,          32'd132,        1'b0, 32'd0,  ST_OK},
        '{OP_RELEASE, 32'd0,          32'd16,         1'b0, 32'd0,  ST_OK},      // table empty
        '{OP_RELEASE, 32'd0,          32'd16,         1'b1, 32'd0,  ST_UNKNOWN},
        '{OP_ALLOC,   32'd10,         32'd0,          1'b0, 32'd0,  ST_OK},
        '{OP_ALLOC,   32'd10,         32'd0,          1'b0, 32'd0,  ST_OK},
        '{OP_RELEASE, 32'd0,          32'd16,         1'b0, 32'd0,  ST_OK},
        '{OP_RELEASE, 32'd0,          32'd16,         1'b0, 32'd0,  ST_OK},      // already free
        '{OP_ALLOC,   32'h8000_0000,  32'h8000_0000,  1'b1, 32'd0,  ST_NOMEM}
    };

    // Heap model state: the block table in allocation order, offsets relative
    // to the heap base, and the two configuration registers.
    logic [31:0]  blk_offset [TBL_DEPTH];
    logic [31:0]  blk_len    [TBL_DEPTH];
    bit           blk_free   [TBL_DEPTH];
    int unsigned  blk_count;
    logic [31:0]  top_offset;
    logic [31:0]  cur_base;
    logic [31:0]  cur_limit;

    t_heap_result pending_results [$];
    int unsigned  mismatch_count;

    // Payload address of table entry idx under the current base, wrapping at 2^32.
    function automatic logic [31:0] payload_addr(input int unsigned idx);
        return cur_base + blk_offset[idx] + HEADER_32;
    endfunction

    // Apply one command to the heap model and return the result it produces.
    function automatic t_heap_result predict_heap_op(input t_opcode op,
                                                     input logic [31:0] size,
                                                     input logic [31:0] addr);
        t_heap_result res;
        logic [33:0]  new_end;
        logic [33:0]  blk_end;
        int unsigned  idx;
        bit           found;

        res.addr = 32'd0;
        res.st   = ST_OK;
        found    = 1'b0;
        if (op == OP_ALLOC) begin
            if (size == 32'd0) begin
                res.st = ST_NULL;
                return res;
            end
            // First fit over the live entries; blocks are never split.
            for (idx = 0; idx < blk_count; idx++) begin
                if (blk_free[idx] && blk_len[idx] >= size) begin
                    blk_free[idx] = 1'b0;
                    res.addr = payload_addr(idx);
                    return res;
                end
            end
            new_end = 34'(top_offset) + HEADER_34 + 34'(size);
            if (new_end > 34'(cur_limit) || blk_count >= TBL_DEPTH) begin
                res.st = ST_NOMEM;
                return res;
            end
            blk_offset[blk_count] = top_offset;
            blk_len[blk_count]    = size;
            blk_free[blk_count]   = 1'b0;
            res.addr   = payload_addr(blk_count);
            blk_count  = blk_count + 1;
            top_offset = new_end[31:0];
            return res;
        end
        if (addr == 32'd0) begin
            res.st = ST_NULL;
            return res;
        end
        // The lowest matching entry wins when payload addresses collide.
        for (idx = 0; idx < blk_count; idx++) begin
            if (payload_addr(idx) == addr) begin
                found = 1'b1;
                break;
            end
        end
        if (!found) begin
            res.st = ST_UNKNOWN;
            return res;
        end
        blk_end = 34'(blk_offset[idx]) + HEADER_34 + 34'(blk_len[idx]);
        if (blk_end == 34'(top_offset) && idx + 1 == blk_count) begin
            top_offset = blk_offset[idx];
            blk_count  = idx;
        end else begin
            blk_free[idx] = 1'b1;
        end
        return res;
    endfunction

    // Gap before a command: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;

        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Hold start low for the given gap, with junk on the command fields.
    task automatic idle_for(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            start             = 1'b0;
            i_opcode          = 1'($urandom_range(0, 1));
            i_request_size    = $urandom;
            i_release_address = $urandom;
        end
    endtask

    // Present one command and hold it until the allocator takes it. The
    // expectation is computed at the accepting edge, so the model always
    // sees commands in the order the hardware does.
    task automatic issue_cmd(input t_opcode op, input logic [31:0] size,
                             input logic [31:0] addr, input bit has_exp,
                             input t_heap_result typed);
        t_heap_result predicted;

        @(negedge i_clk);
        start             = 1'b1;
        i_opcode          = op;
        i_request_size    = size;
        i_release_address = addr;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        predicted = predict_heap_op(op, size, addr);
        pending_results.push_back(has_exp ? typed : predicted);
    endtask

    // Lower start and wait until every outstanding result transaction has come back.
    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Register writes only happen with the allocator idle.
    task automatic write_cfg(input t_cfg_index idx, input logic [31:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_data  = $urandom;
        if (idx == CFG_HEAP_BASE)
            cur_base = value;
        else
            cur_limit = value;
    endtask

    // Result checker: every strobed result must match the oldest expectation.
    always @(posedge i_clk) begin
        t_heap_result exp_res;

        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, address %h status %0d",
                         $time, o_payload_address, o_status);
                mismatch_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_payload_address !== exp_res.addr) begin
                    $display("%0t: payload address mismatch, expected %h, actual %h",
                             $time, exp_res.addr, o_payload_address);
                    mismatch_count++;
                end
                if (o_status !== exp_res.st) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, exp_res.st, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    // Main stimulus: reset, directed table, then random phases under
    // several register settings, including both extremes of each register.
    initial begin
        t_heap_phase  phases [6];
        t_heap_result typed;
        t_heap_result no_typed;
        t_opcode      op;
        logic [31:0]  size;
        logic [31:0]  addr;
        int unsigned  roll;
        int unsigned  ph;
        int unsigned  k;

        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_opcode          = OP_ALLOC;
        i_request_size    = 32'd0;
        i_release_address = 32'd0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = CFG_HEAP_BASE;
        i_cfg_data        = 32'd0;
        mismatch_count    = 0;
        blk_count         = 0;
        top_offset        = 32'd0;
        cur_base          = HEAP_BASE_RST;
        cur_limit         = HEAP_LIMIT_RST;
        no_typed          = '{32'd0, ST_OK};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (k = 0; k < N_ROWS; k++) begin
            idle_for(pick_gap());
            typed = '{directed_rows[k].exp_addr, directed_rows[k].exp_st};
            issue_cmd(directed_rows[k].op, directed_rows[k].size, directed_rows[k].addr,
                      directed_rows[k].has_exp, typed);
        end

        // The first phase runs with the largest possible limit so the table fills up;
        // the zero limit phase can only reuse freed blocks, and the high bases
        // make payload addresses wrap around.
        phases[0] = '{32'h0000_0000, 32'hFFFF_FFFF, 80};
        phases[1] = '{32'h0000_1000, 32'd4096,      60};
        phases[2] = '{32'hFFFF_FFFF, 32'h0000_0000, 50};
        phases[3] = '{$urandom,      32'($urandom_range(0, 32'h0010_0000)), 55};
        phases[4] = '{32'h8000_0000, 32'd65536,     40};
        phases[5] = '{32'hFFFF_FFF0, 32'hFFFF_FFFF, 85};

        for (ph = 0; ph < 6; ph++) begin
            write_cfg(CFG_HEAP_BASE, phases[ph].base);
            write_cfg(CFG_HEAP_LIMIT, phases[ph].limit);
            for (k = 0; k < 80; k++) begin
                // A stretch of back-to-back commands in every phase, and one
                // pause until the allocator has answered everything.
                if (k == 40)
                    drain_results();
                if (k < 20 || k > 35)
                    idle_for(pick_gap());

                op = ($urandom_range(0, 99) < phases[ph].alloc_pct) ? OP_ALLOC : OP_RELEASE;

                roll = $urandom_range(0, 99);
                if (roll < 6)
                    size = 32'd0;
                else if (roll < 70)
                    size = $urandom_range(1, 256);
                else if (roll < 85)
                    size = $urandom_range(257, 8192);
                else
                    size = $urandom;

                // Releases mostly target live blocks so the table drains and
                // the heap top moves; the rest are null or stray addresses.
                roll = $urandom_range(0, 99);
                if (blk_count != 0 && roll < 65)
                    addr = payload_addr($urandom_range(0, blk_count - 1));
                else if (roll < 75)
                    addr = 32'd0;
                else
                    addr = $urandom;

                issue_cmd(op, size, addr, 1'b0, no_typed);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: the slowest legal run is well under a tenth of this.
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
